// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error(msg);

// clocked check that also covers the reset cycles
`define ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
  else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
// types and constants of the text console writer
package tcw_pkg;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int NCELLS = ROWS * COLS;
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLS;
  localparam int COPY_CELLS = NCELLS - COLS;

  localparam int POS_W = 11;
  localparam int CELL_W = 16;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] ATTR_RESET   = 8'h07;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       char_code;
    logic [POS_W-1:0] cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
  } tcw_rsp_t;

  // control from the sequencer to the cursor unit
  typedef struct packed {
    logic       put;
    logic       clear;
    logic [7:0] ch;
  } cur_ctl_t;

  // what a put of the presented character does to the store
  typedef struct packed {
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [7:0]       wr_char;
    logic             scroll;
  } cur_plan_t;

endpackage

// ===== src/tcw_ram.sv =====
// generic simple dual-port ram with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/tcw_cursor.sv =====
// cursor registers and the put decode that moves them
module tcw_cursor (
  input  logic                    clk,
  input  logic                    rst,
  input  tcw_pkg::cur_ctl_t       ctl,
  output logic [tcw_pkg::POS_W-1:0] pos,
  output tcw_pkg::cur_plan_t      plan
);
  import tcw_pkg::*;

  logic [ROW_W-1:0] row, row_next;
  logic [COL_W-1:0] col, col_next;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] col_ext;
  logic             adv;

  always_comb begin
    row_next = row;
    col_next = col;
    pos_next = pos;
    adv      = 1'b0;
    plan     = '0;
    col_ext  = POS_W'(col);
    case (ctl.ch)
      CH_NEWLINE: begin
        col_next = '0;
        pos_next = pos - col_ext + POS_W'(COLS);
        adv      = 1'b1;
      end
      CH_RETURN: begin
        col_next = '0;
        pos_next = pos - col_ext;
      end
      CH_BACKSPACE: begin
        if (col != '0) begin
          col_next      = col - COL_W'(1);
          pos_next      = pos - POS_W'(1);
          plan.wr_en    = 1'b1;
          plan.wr_addr  = pos - POS_W'(1);
          plan.wr_char  = CH_SPACE;
        end
      end
      default: begin
        plan.wr_en   = 1'b1;
        plan.wr_addr = pos;
        plan.wr_char = ctl.ch;
        pos_next     = pos + POS_W'(1);
        if (col == COL_W'(COLS - 1)) begin
          col_next = '0;
          adv      = 1'b1;
        end else begin
          col_next = col + COL_W'(1);
        end
      end
    endcase
    // column is always 0 here; on a scroll the cursor lands on the start of the last row
    if (adv) begin
      if (row == ROW_W'(ROWS - 1)) begin
        plan.scroll = 1'b1;
        pos_next    = POS_W'(LAST_ROW_BASE);
      end else begin
        row_next = row + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      row <= '0;
      col <= '0;
      pos <= '0;
    end else if (ctl.put) begin
      row <= row_next;
      col <= col_next;
      pos <= pos_next;
    end
  end

endmodule

// ===== src/text_console_writer_core.sv =====
// text console writer top level: request sequencer, cell ram and cursor
// Text console over an 80 x 25 store of 16-bit cells (attribute high byte, character low
// byte) held in one single-port-write, registered-read ram. After reset the block runs a
// clearing pass over every cell, one cell per cycle, before it takes the first request.
// A put without scroll and an unused command go from acceptance to the done state, then to
// the response register; a read passes the read state first. A clear sweeps every cell. A
// put that scrolls copies 1920 cells through the ram, one per cycle, then blanks the last row.
// One request is worked on at a time; its response waits in an output register, so the next
// request is taken as soon as the sequencer is free. The attribute register may be written
// whenever the block is idle, including during the clearing pass after reset.
module text_console_writer_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              req_valid,
  output logic              req_ready,
  input  tcw_pkg::tcw_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output tcw_pkg::tcw_rsp_t rsp
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_READ,
    S_COPY,
    S_DONE
  } state_t;

  state_t state;

  logic [7:0]        attr;
  logic [7:0]        fill_attr;
  logic              init_done;
  logic [POS_W-1:0]  ptr;
  logic              cp_rd;
  logic              wv;
  logic [POS_W-1:0]  wa;
  logic              rd_oob;
  logic [CELL_W-1:0] res_data;

  logic              accept;
  logic              rd_oob_now;
  logic              rsp_load;
  cur_ctl_t          ctl;
  cur_plan_t         plan;
  logic [POS_W-1:0]  pos;

  logic              ram_wr_en;
  logic [POS_W-1:0]  ram_wr_addr;
  logic [CELL_W-1:0] ram_wr_data;
  logic [POS_W-1:0]  ram_rd_addr;
  logic [CELL_W-1:0] ram_rd_data;

  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign rd_oob_now = (req.cell_index >= POS_W'(NCELLS));
  assign rsp_load   = (state == S_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    ctl.put   = accept && (req.cmd == CMD_PUT);
    ctl.clear = accept && (req.cmd == CMD_CLEAR);
    ctl.ch    = req.char_code;
  end

  tcw_cursor u_cursor (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .pos  (pos),
    .plan (plan)
  );

  // ram port selection per state
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = ptr;
    ram_wr_data = {fill_attr, CH_SPACE};
    ram_rd_addr = ptr;
    unique case (state)
      S_IDLE: begin
        ram_wr_en   = ctl.put && plan.wr_en;
        ram_wr_addr = plan.wr_addr;
        ram_wr_data = {attr, plan.wr_char};
        ram_rd_addr = rd_oob_now ? '0 : req.cell_index;
      end
      S_FILL: begin
        ram_wr_en = 1'b1;
      end
      S_COPY: begin
        ram_wr_en   = wv;
        ram_wr_addr = wa;
        ram_wr_data = ram_rd_data;
      end
      S_READ, S_DONE: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      ptr       <= '0;
      fill_attr <= ATTR_RESET;
      attr      <= ATTR_RESET;
      init_done <= 1'b0;
      cp_rd     <= 1'b0;
      wv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        attr <= cfg_wr_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_data <= '0;
            rd_oob   <= rd_oob_now;
            unique case (req.cmd)
              CMD_PUT: begin
                if (plan.scroll && (COPY_CELLS != 0)) begin
                  state <= S_COPY;
                  ptr   <= POS_W'(COLS);
                  cp_rd <= 1'b1;
                  wv    <= 1'b0;
                end else if (plan.scroll) begin
                  state     <= S_FILL;
                  ptr       <= POS_W'(LAST_ROW_BASE);
                  fill_attr <= attr;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_CLEAR: begin
                state     <= S_FILL;
                ptr       <= '0;
                fill_attr <= attr;
              end
              CMD_READ: begin
                state <= S_READ;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          if (!rd_oob) begin
            res_data <= ram_rd_data;
          end
          state <= S_DONE;
        end
        S_COPY: begin
          // read at ptr, write the cell in the next cycle one row lower
          if (cp_rd) begin
            ptr <= ptr + POS_W'(1);
            if (ptr == POS_W'(NCELLS - 1)) begin
              cp_rd <= 1'b0;
            end
          end
          wv <= cp_rd;
          wa <= ptr - POS_W'(COLS);
          if (!cp_rd && wv) begin
            state     <= S_FILL;
            ptr       <= POS_W'(LAST_ROW_BASE);
            fill_attr <= attr;
          end
        end
        S_FILL: begin
          ptr <= ptr + POS_W'(1);
          if (ptr == POS_W'(NCELLS - 1)) begin
            state     <= init_done ? S_DONE : S_IDLE;
            init_done <= 1'b1;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp.cursor_pos <= pos;
            rsp.cell_data  <= res_data;
            state          <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== src/tcw_checker.sv =====
// port-level checks of the text console writer, bound to the top level
`include "assert_macros.svh"

module tcw_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input tcw_pkg::tcw_rsp_t rsp
);
  import tcw_pkg::*;

  // a response that is not taken holds
  `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp not held")

  // cursor always lies inside the screen
  `ASSERT_CLK(a_pos_range, rsp_valid |-> (rsp.cursor_pos < POS_W'(NCELLS)), "cursor off screen")

  // one request at a time: ready drops after a request is taken
  `ASSERT_CLK(a_one_req, req_valid && req_ready |=> !req_ready, "request taken while busy")

  // the clearing pass after reset keeps requests out
  `ASSERT_RST(a_init_busy, rst |=> !req_ready, "request taken before the store is cleared")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_ready   (req_ready),
  .rsp_valid   (rsp_valid),
  .rsp_ready   (rsp_ready),
  .rsp         (rsp)
);
